/* rtl/core/bta_pkg.sv */
package bta_pkg;

    // sizing
    localparam int SLOTS       = 32;
    localparam int TICKET_BITS = 16;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int NEXT_W      = $clog2(SLOTS + 1);
    localparam int GROUP_SIZE  = 8;
    localparam int NGROUPS     = (SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    // fixed field widths
    localparam int SLOT_W    = 5;
    localparam int TAG_W     = 32;
    localparam int TKT_OUT_W = 16;
    localparam int SVC_W     = 32;
    localparam int STAT_W    = 2;

    // service counter starts at ascii 'a'
    localparam logic [SVC_W-1:0] SERVICE_RESET = SVC_W'(97);

    // request kinds
    localparam logic REQ_TAKE  = 1'b0;
    localparam logic REQ_ENTER = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SLOT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
    } t_req;

    typedef struct packed {
        logic                 resp_type;
        logic [SLOT_W-1:0]    slot_out;
        logic [TKT_OUT_W-1:0] ticket;
        logic                 granted;
        logic [SVC_W-1:0]     service_value;
        logic [TAG_W-1:0]     tag_out;
        logic [STAT_W-1:0]    status;
    } t_resp;

    // classified word handed from front to back
    typedef struct packed {
        logic              is_enter;
        logic              slot_ok;
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  idx;
        logic [TAG_W-1:0]  tag;
    } t_job;

endpackage

/* rtl/core/bakery_ticket_arbiter.sv */
// bakery-style ticket lock
//
// request channel: drive i_req and raise start; the word is taken at a rising
// edge where start is high and busy is low. req_type take gives the caller the
// next client slot and a ticket one above the largest ticket held; req_type
// enter asks for the critical region on behalf of a slot and is granted only
// when no other slot holds a smaller nonzero ticket (ties to the lower slot)
// result channel: o_done is high for one cycle with the response word on
// o_resp; the receiver has no way to hold it off, so it must take it then
// the front keeps a two-word queue; busy is high only while that queue is full
// an accepted word waits in the queue, then the back end takes it in two steps
// (one to reduce the ticket file into group maxima and the ahead check, one to
// commit and register the response) and raises o_done; it takes no new word
// from the queue until it has committed the one in hand
// reset (synchronous, active low): all tickets cleared, slot counter zero,
// service counter at 97, queue empty, no response pending
module bakery_ticket_arbiter import bta_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_req  i_req,
    output logic  o_done,
    output t_resp o_resp
);

    logic job_valid;
    t_job job;
    logic pop;

    // front: accept, classify, queue
    bta_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_pop       (pop),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // back: ticket file, counters and the response register
    bta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_resp      (o_resp)
    );

endmodule

/* rtl/core/bta_front.sv */
module bta_front import bta_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    input  logic i_pop,
    output logic o_job_valid,
    output t_job o_job
);

    t_job              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push;
    logic              pop;
    t_job              job_in;

    // classify the incoming word
    always_comb begin
        job_in.is_enter = (i_req.req_type == REQ_ENTER);
        job_in.slot_ok  = (int'(i_req.slot) < SLOTS);
        job_in.slot     = i_req.slot;
        job_in.idx      = IDX_W'(i_req.slot);
        job_in.tag      = i_req.tag;
    end

    assign busy        = (r_cnt == QCNT_W'(QDEPTH));
    assign push        = start && !busy;
    assign o_job_valid = (r_cnt != '0);
    assign pop         = i_pop && o_job_valid;
    assign o_job       = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
    end

endmodule

/* rtl/core/bta_back.sv */
module bta_back import bta_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_job_valid,
    input  t_job  i_job,
    output logic  o_pop,
    output logic  o_done,
    output t_resp o_resp
);

    localparam logic P_EVAL   = 1'b0;
    localparam logic P_COMMIT = 1'b1;

    logic                   r_phase;
    logic [TICKET_BITS-1:0] r_tickets [SLOTS];
    logic [NEXT_W-1:0]      r_next;
    logic [SVC_W-1:0]       r_svc;
    t_job                   r_item;
    logic [TICKET_BITS-1:0] r_gmax [NGROUPS];
    logic [TICKET_BITS-1:0] n_gmax [NGROUPS];
    logic                   r_ahead, n_ahead;
    logic                   r_done;
    t_resp                  r_resp;

    logic [TICKET_BITS-1:0] mine;
    logic [TICKET_BITS-1:0] top;
    logic                   take_ok;
    logic                   no_slot;
    logic                   overflow;
    logic [IDX_W-1:0]       new_idx;
    logic [SVC_W-1:0]       svc_inc;

    assign o_pop  = (r_phase == P_EVAL) && i_job_valid;
    assign o_done = r_done;
    assign o_resp = r_resp;

    // evaluation: per-group maxima and the someone-ahead check
    assign mine = i_job.slot_ok ? r_tickets[i_job.idx] : '0;

    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            n_gmax[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < SLOTS) begin
                    if (r_tickets[g * GROUP_SIZE + k] > n_gmax[g]) begin
                        n_gmax[g] = r_tickets[g * GROUP_SIZE + k];
                    end
                end
            end
        end
    end

    always_comb begin
        n_ahead = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (IDX_W'(j) != i_job.idx && r_tickets[j] != '0 && mine != '0) begin
                if (r_tickets[j] < mine
                    || (r_tickets[j] == mine && IDX_W'(j) < i_job.idx)) begin
                    n_ahead = 1'b1;
                end
            end
        end
    end

    // commit: final max over the group maxima
    always_comb begin
        top = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            if (r_gmax[g] > top) begin
                top = r_gmax[g];
            end
        end
    end

    assign no_slot  = (r_next >= NEXT_W'(SLOTS));
    assign overflow = (top == '1);
    assign take_ok  = !r_item.is_enter && !no_slot && !overflow;
    assign new_idx  = IDX_W'(r_next);
    assign svc_inc  = r_svc + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_EVAL;
            r_done  <= 1'b0;
            r_next  <= '0;
            r_svc   <= SERVICE_RESET;
            for (int j = 0; j < SLOTS; j++) begin
                r_tickets[j] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                P_EVAL: begin
                    if (i_job_valid) begin
                        r_phase <= P_COMMIT;
                    end
                end
                P_COMMIT: begin
                    r_phase <= P_EVAL;
                    r_done  <= 1'b1;
                    if (take_ok) begin
                        r_tickets[new_idx] <= top + 1'b1;
                        r_next             <= r_next + 1'b1;
                    end
                    if (r_item.is_enter && !r_ahead) begin
                        r_svc <= svc_inc;
                        if (r_item.slot_ok) begin
                            r_tickets[r_item.idx] <= '0;
                        end
                    end
                end
                default: begin
                    r_phase <= P_EVAL;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_phase == P_EVAL && i_job_valid) begin
            r_item  <= i_job;
            r_ahead <= n_ahead;
            for (int g = 0; g < NGROUPS; g++) begin
                r_gmax[g] <= n_gmax[g];
            end
        end
        if (r_phase == P_COMMIT) begin
            r_resp.resp_type     <= r_item.is_enter ? REQ_ENTER : REQ_TAKE;
            r_resp.tag_out       <= r_item.tag;
            r_resp.slot_out      <= '0;
            r_resp.ticket        <= '0;
            r_resp.granted       <= 1'b0;
            r_resp.service_value <= '0;
            r_resp.status        <= ST_OK;
            if (r_item.is_enter) begin
                r_resp.slot_out <= r_item.slot;
                if (!r_ahead) begin
                    r_resp.granted       <= 1'b1;
                    r_resp.service_value <= svc_inc;
                end
            end else if (no_slot) begin
                r_resp.status <= ST_NO_SLOT;
            end else if (overflow) begin
                r_resp.status <= ST_OVERFLOW;
            end else begin
                r_resp.slot_out <= SLOT_W'(r_next);
                r_resp.ticket   <= TKT_OUT_W'(top + 1'b1);
            end
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import bta_pkg::*;

    // two copies of the lock state: one walks ahead with the stimulus plan so the
    // generator can aim enter words at slots that hold tickets, the other follows
    // the words the block actually takes
    localparam int PLAN_VIEW = 0;
    localparam int DUT_VIEW  = 1;

    localparam int RANDOM_WORDS = 1330;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SHOWN_ERRORS = 10;

    typedef struct {
        t_req req;
        int   gap_pct;
    } t_pending_word;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_done;
    t_resp o_resp;

    // per-view lock state
    logic [TICKET_BITS-1:0] held_ticket [2][SLOTS];
    int unsigned            slots_issued [2];
    logic [SVC_W-1:0]       service_cnt [2];

    t_pending_word req_backlog[$];
    t_resp         due_responses[$];
    int            mismatches = 0;
    int            cycle_cnt  = 0;

    bakery_ticket_arbiter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_resp  (o_resp)
    );

    always #1 i_clk = ~i_clk;

    // apply one request word to the chosen view and return the response it earns
    function automatic t_resp serve_request(input int v, input t_req rq);
        t_resp                  rs;
        logic [TICKET_BITS-1:0] top;
        logic [TICKET_BITS-1:0] mine;
        bit                     ahead;
        int                     s;
        rs           = '0;
        rs.resp_type = rq.req_type;
        rs.tag_out   = rq.tag;
        rs.status    = ST_OK;
        if (rq.req_type == REQ_TAKE) begin
            top = '0;
            for (int j = 0; j < SLOTS; j++)
                if (held_ticket[v][j] > top) top = held_ticket[v][j];
            if (slots_issued[v] >= SLOTS) begin
                rs.status = ST_NO_SLOT;
            end else if (top == {TICKET_BITS{1'b1}}) begin
                rs.status = ST_OVERFLOW;
            end else begin
                s                 = slots_issued[v];
                held_ticket[v][s] = top + 1'b1;
                rs.slot_out       = SLOT_W'(s);
                rs.ticket         = TKT_OUT_W'(held_ticket[v][s]);
                slots_issued[v]   = slots_issued[v] + 1;
            end
        end else begin
            s           = rq.slot;
            rs.slot_out = rq.slot;
            mine        = (s < SLOTS) ? held_ticket[v][s] : '0;
            ahead       = 1'b0;
            // a slot with no ticket has nobody ahead of it
            if (mine != 0)
                for (int j = 0; j < SLOTS; j++)
                    if (j != s && held_ticket[v][j] != 0 &&
                        (held_ticket[v][j] < mine || (held_ticket[v][j] == mine && j < s)))
                        ahead = 1'b1;
            if (!ahead) begin
                service_cnt[v]   = service_cnt[v] + 1'b1;
                rs.granted       = 1'b1;
                rs.service_value = service_cnt[v];
                if (s < SLOTS) held_ticket[v][s] = '0;
            end
        end
        return rs;
    endfunction

    // queue one word for the driver, keeping the plan view in step
    task automatic queue_request(input logic kind, input int s, input logic [TAG_W-1:0] tg,
                                 input int gap);
        t_pending_word w;
        t_resp         unused;
        w.req.req_type = kind;
        w.req.slot     = SLOT_W'(s);
        w.req.tag      = tg;
        w.gap_pct      = gap;
        unused         = serve_request(PLAN_VIEW, w.req);
        req_backlog.push_back(w);
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatches < SHOWN_ERRORS) $display("%s", msg);
        mismatches++;
    endtask

    // driver: presents backlog words, records a prediction for every accepted word
    always @(posedge i_clk) begin : drive_requests
        t_resp         predicted;
        t_pending_word nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else begin
            // word taken at this edge
            if (start && !busy) begin
                predicted = serve_request(DUT_VIEW, i_req);
                due_responses.push_back(predicted);
            end
            // line free: offer the next word or idle this cycle
            if (!start || !busy) begin
                if (req_backlog.size() != 0 &&
                    $urandom_range(0, 99) >= req_backlog[0].gap_pct) begin
                    nxt = req_backlog.pop_front();
                    i_req <= nxt.req;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed response is matched against the oldest prediction
    always @(posedge i_clk) begin : check_responses
        t_resp want;
        if (i_rst_n && o_done) begin
            if (due_responses.size() == 0) begin
                note_mismatch($sformatf("unexpected response word %p", o_resp));
            end else begin
                want = due_responses.pop_front();
                if (o_resp.resp_type !== want.resp_type ||
                    o_resp.slot_out !== want.slot_out ||
                    o_resp.ticket !== want.ticket ||
                    o_resp.granted !== want.granted ||
                    o_resp.service_value !== want.service_value ||
                    o_resp.tag_out !== want.tag_out ||
                    o_resp.status !== want.status)
                    note_mismatch($sformatf("response mismatch: expected %p, got %p",
                                            want, o_resp));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        int                     lowest;
        int                     pick;
        int                     roll;
        int                     gap;
        int                     held[$];
        logic [TICKET_BITS-1:0] best;

        for (int v = 0; v < 2; v++) begin
            for (int j = 0; j < SLOTS; j++) held_ticket[v][j] = '0;
            slots_issued[v] = 0;
            service_cnt[v]  = SERVICE_RESET;
        end

        // directed: entry with no ticket at both slot extremes and tag extremes
        queue_request(REQ_ENTER, 0, 32'h0000_0000, 35);
        queue_request(REQ_ENTER, SLOTS - 1, 32'hffff_ffff, 35);
        // three tickets in a row; the slot field of a take is ignored
        queue_request(REQ_TAKE, SLOTS - 1, 32'h8000_0001, 35);
        queue_request(REQ_TAKE, 0, 32'h7fff_fffe, 35);
        queue_request(REQ_TAKE, 21, 32'h5555_5555, 35);
        // later tickets are refused while an earlier one is held
        queue_request(REQ_ENTER, 2, 32'haaaa_aaaa, 35);
        queue_request(REQ_ENTER, 1, 32'h1234_5678, 35);
        queue_request(REQ_ENTER, 0, 32'h0000_0001, 35);
        queue_request(REQ_ENTER, 2, 32'h0000_0002, 35);
        queue_request(REQ_ENTER, 1, 32'h0000_0003, 35);
        // new ticket sits above the largest still held
        queue_request(REQ_TAKE, 10, 32'h0000_0004, 35);
        queue_request(REQ_ENTER, 3, 32'h0000_0005, 35);
        queue_request(REQ_ENTER, 2, 32'h0000_0006, 35);
        queue_request(REQ_ENTER, 3, 32'h0000_0007, 35);
        // with nothing held the ticket sequence starts over at one
        queue_request(REQ_TAKE, 0, 32'hdead_beef, 35);
        // a ticketless slot gets in even while another slot waits
        queue_request(REQ_ENTER, 5, 32'hcafe_f00d, 35);
        queue_request(REQ_ENTER, 4, 32'h0f0f_0f0f, 35);

        // random part: mostly enter words aimed at ticket holders, takes spread out
        // so the slot supply runs dry about halfway and no-slot takes follow;
        // ticket overflow stays out of reach since tickets never pass the slot count
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            gap = (n < RANDOM_WORDS / 3) ? 35 : (n < 2 * RANDOM_WORDS / 3) ? 77 : 0;
            if ($urandom_range(0, 23) == 0) begin
                queue_request(REQ_TAKE, $urandom_range(0, SLOTS - 1), $urandom, gap);
            end else begin
                held.delete();
                lowest = -1;
                best   = '1;
                for (int j = 0; j < SLOTS; j++)
                    if (held_ticket[PLAN_VIEW][j] != 0) begin
                        held.push_back(j);
                        if (lowest < 0 || held_ticket[PLAN_VIEW][j] < best) begin
                            lowest = j;
                            best   = held_ticket[PLAN_VIEW][j];
                        end
                    end
                roll = $urandom_range(0, 99);
                if (held.size() != 0 && roll < 45)
                    pick = lowest;
                else if (held.size() != 0 && roll < 70)
                    pick = held[$urandom_range(0, held.size() - 1)];
                else
                    pick = $urandom_range(0, SLOTS - 1);
                queue_request(REQ_ENTER, pick, $urandom, gap);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every word to go in and every response to come back
        @(posedge i_clk);
        while (req_backlog.size() != 0 || start || due_responses.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (due_responses.size() != 0)
            note_mismatch($sformatf("%0d responses never arrived", due_responses.size()));
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
